/* rtl/core/boot_image_section_validator_assert.svh */
// assertion helpers shared by the checker
`ifndef BOOT_IMAGE_SECTION_VALIDATOR_ASSERT_SVH
`define BOOT_IMAGE_SECTION_VALIDATOR_ASSERT_SVH

// same-cycle implication, off while reset is low
`define BISV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bisv assertion failed: same-cycle implication");

// next-cycle implication, off while reset is low
`define BISV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bisv assertion failed: next-cycle implication");

`endif

/* rtl/core/bisv_pkg.sv */
package bisv_pkg;

    typedef enum logic [1:0] {
        MODE_BEGIN   = 2'd0,
        MODE_SECTION = 2'd1,
        MODE_FINISH  = 2'd2,
        MODE_NOP     = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ERR_NONE         = 4'd0,
        ERR_BOUNDS       = 4'd1,
        ERR_COPY         = 4'd2,
        ERR_WINDOW       = 4'd3,
        ERR_OVERLAP      = 4'd4,
        ERR_FRAMEBUF     = 4'd5,
        ERR_HASH         = 4'd6,
        ERR_MAIN_ENTRY   = 4'd7,
        ERR_SECOND_ENTRY = 4'd8,
        ERR_TOO_MANY     = 4'd9
    } t_err;

    typedef enum logic [1:0] {
        CFG_FILE_LENGTH  = 2'd0,
        CFG_SCREEN_INIT  = 2'd1,
        CFG_MAIN_ENTRY   = 2'd2,
        CFG_SECOND_ENTRY = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CHECK,
        ST_SCAN,
        ST_RESOLVE,
        ST_EMIT
    } t_state;

    localparam int          FILE_LEN_W     = 28;
    localparam int          HELD_W         = 3;
    localparam int          SECTOR_BITS    = 9;
    localparam logic [27:0] FILE_LEN_RESET = 28'd512;
    localparam logic [31:0] MIN_OFFSET     = 32'h0000_0200;
    localparam logic [31:0] COPY_KIND_MAX  = 32'd2;
    localparam logic [31:0] SECOND_MIN     = 32'h1800_0000;

    // load windows, end exclusive, 33 bits to hold address plus length
    localparam logic [32:0] WIN0_LO = 33'h0_0800_0000;
    localparam logic [32:0] WIN0_HI = 33'h0_0810_0000;
    localparam logic [32:0] WIN1_LO = 33'h0_1800_0000;
    localparam logic [32:0] WIN1_HI = 33'h0_1860_0000;
    localparam logic [32:0] WIN2_LO = 33'h0_1FF0_0000;
    localparam logic [32:0] WIN2_HI = 33'h0_1FFF_FC00;
    localparam logic [32:0] WIN3_LO = 33'h0_2000_0000;
    localparam logic [32:0] WIN3_HI = 33'h0_2800_0000;

    localparam logic [32:0] FB_LEN   = 33'h0_0007_E900;
    localparam logic [32:0] FB0_BASE = 33'h0_1830_0000;
    localparam logic [32:0] FB1_BASE = 33'h0_1840_0000;
    localparam logic [32:0] FB0_END  = FB0_BASE + FB_LEN;
    localparam logic [32:0] FB1_END  = FB1_BASE + FB_LEN;

    localparam logic [32:0] ENTRY_W_THUMB = 33'd2;
    localparam logic [32:0] ENTRY_W_WORD  = 33'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] sec_offset;
        logic [31:0] sec_dest;
        logic [31:0] sec_length;
        logic [31:0] copy_kind;
        logic        digest_ok;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic [3:0]  error_code;
        logic [2:0]  held_count;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic calc;
        logic clear_img;
        logic count_header;
        logic set_too_many;
        logic check;
        logic scan;
        logic resolve;
        logic emit;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  err_present;
        logic  headers_full;
        logic  len_zero;
        logic  count_zero;
        logic  scan_last;
        logic  out_free;
    } t_status;

endpackage

/* rtl/core/bisv_if.sv */
interface bisv_in_if;
    import bisv_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bisv_out_if;
    import bisv_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bisv_cfg_if;
    import bisv_pkg::*;
    logic        valid;
    logic        ready;
    t_cfg_idx    index;
    logic [31:0] value;
    modport source (output valid, output index, output value, input ready);
    modport sink (input valid, input index, input value, output ready);
endinterface

/* rtl/core/bisv_ctrl.sv */
module bisv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bisv_pkg::t_status i_status,
    output bisv_pkg::t_cmd    o_cmd
);
    import bisv_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.calc = 1'b1;
                unique case (i_status.mode)
                    MODE_BEGIN: begin
                        o_cmd.clear_img = 1'b1;
                        n_state         = ST_EMIT;
                    end
                    MODE_SECTION: begin
                        if (i_status.err_present) begin
                            n_state = ST_EMIT;
                        end else if (i_status.headers_full) begin
                            o_cmd.set_too_many = 1'b1;
                            n_state            = ST_EMIT;
                        end else begin
                            // empty slot counts as a header but is not checked
                            o_cmd.count_header = 1'b1;
                            n_state = i_status.len_zero ? ST_EMIT : ST_CHECK;
                        end
                    end
                    MODE_FINISH: begin
                        if (i_status.err_present) begin
                            n_state = ST_EMIT;
                        end else begin
                            n_state = i_status.count_zero ? ST_RESOLVE : ST_SCAN;
                        end
                    end
                    MODE_NOP: begin
                        n_state = ST_EMIT;
                    end
                    default: begin
                        n_state = ST_EMIT;
                    end
                endcase
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_status.count_zero ? ST_RESOLVE : ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_RESOLVE;
                end
            end
            ST_RESOLVE: begin
                o_cmd.resolve = 1'b1;
                n_state       = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/bisv_dp.sv */
module bisv_dp #(
    parameter int MAX_SECTIONS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bisv_pkg::t_cmd      i_cmd,
    output bisv_pkg::t_status   o_status,
    input  bisv_pkg::t_in_item  i_item,
    input  logic                i_cfg_valid,
    input  bisv_pkg::t_cfg_idx  i_cfg_index,
    input  logic [31:0]         i_cfg_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bisv_pkg::t_out_item o_out_item
);
    import bisv_pkg::*;

    localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
    localparam int CW1   = CNT_W + 1;
    localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

    function automatic logic within_win(logic [31:0] a, logic [32:0] a_end,
                                        logic [32:0] lo, logic [32:0] hi);
        return ({1'b0, a} >= lo) && (a_end <= hi);
    endfunction

    function automatic logic collide(logic [31:0] a, logic [32:0] a_end,
                                     logic [32:0] b, logic [32:0] b_end);
        return ({1'b0, a} < b_end) && (b < a_end);
    endfunction

    // configuration
    logic [FILE_LEN_W-1:0] r_file_length;
    logic                  r_screen_init;
    logic [31:0]           r_main_entry;
    logic [31:0]           r_second_entry;

    // captured item and derived ends
    t_mode       r_mode;
    logic [31:0] r_off;
    logic [31:0] r_dest;
    logic [31:0] r_len;
    logic [31:0] r_kind;
    logic        r_dig;
    logic [32:0] r_off_end;
    logic [32:0] r_dest_end;
    logic [31:0] r_main_addr;
    logic [32:0] r_main_end;
    logic [31:0] r_sec_addr;
    logic [32:0] r_sec_end;

    t_err        r_pre;
    logic        r_fb;
    logic        r_overlap;
    logic        r_main_found;
    logic        r_sec_found;
    logic [IDX_W-1:0] r_idx;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_headers;
    t_err             r_err;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [31:0] r_st_dest [MAX_SECTIONS];
    logic [31:0] r_st_len  [MAX_SECTIONS];
    logic [31:0] r_st_off  [MAX_SECTIONS];

    logic        bounds_bad;
    logic        copy_bad;
    logic        win_ok;
    logic        fb_hit;
    t_err        pre_code;
    logic [31:0] s_dest;
    logic [31:0] s_len;
    logic [31:0] s_off;
    logic [32:0] s_dest_end;
    logic [32:0] s_off_end;
    logic        scan_hit;
    logic        main_in;
    logic        sec_in;
    logic        main_mis;
    logic        sec_mis;
    t_err        sec_code;
    t_err        fin_code;
    t_err        res_code;
    logic        store_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_length  <= FILE_LEN_RESET;
            r_screen_init  <= 1'b0;
            r_main_entry   <= '0;
            r_second_entry <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FILE_LENGTH:  r_file_length  <= i_cfg_value[FILE_LEN_W-1:0];
                CFG_SCREEN_INIT:  r_screen_init  <= i_cfg_value[0];
                CFG_MAIN_ENTRY:   r_main_entry   <= i_cfg_value;
                CFG_SECOND_ENTRY: r_second_entry <= i_cfg_value;
                default: ;
            endcase
        end
    end

    // check logic on the captured item
    always_comb begin
        bounds_bad = (r_off < MIN_OFFSET) || (|r_off[SECTOR_BITS-1:0])
                     || (|r_len[SECTOR_BITS-1:0]) || (|r_dest[1:0])
                     || (r_off_end > {5'b0, r_file_length});
        copy_bad   = r_kind > COPY_KIND_MAX;
        win_ok     = within_win(r_dest, r_dest_end, WIN0_LO, WIN0_HI)
                     || within_win(r_dest, r_dest_end, WIN1_LO, WIN1_HI)
                     || within_win(r_dest, r_dest_end, WIN2_LO, WIN2_HI)
                     || within_win(r_dest, r_dest_end, WIN3_LO, WIN3_HI);
        fb_hit     = r_screen_init
                     && (collide(r_dest, r_dest_end, FB0_BASE, FB0_END)
                         || collide(r_dest, r_dest_end, FB1_BASE, FB1_END));
        if (bounds_bad) begin
            pre_code = ERR_BOUNDS;
        end else if (copy_bad) begin
            pre_code = ERR_COPY;
        end else if (!win_ok) begin
            pre_code = ERR_WINDOW;
        end else begin
            pre_code = ERR_NONE;
        end
    end

    // one stored section per cycle
    always_comb begin
        s_dest     = r_st_dest[r_idx];
        s_len      = r_st_len[r_idx];
        s_off      = r_st_off[r_idx];
        s_dest_end = {1'b0, s_dest} + {1'b0, s_len};
        s_off_end  = {1'b0, s_off} + {1'b0, s_len};
        scan_hit   = collide(r_dest, r_dest_end, {1'b0, s_dest}, s_dest_end)
                     || collide(r_off, r_off_end, {1'b0, s_off}, s_off_end);
        main_in    = within_win(r_main_addr, r_main_end, {1'b0, s_dest}, s_dest_end);
        sec_in     = within_win(r_sec_addr, r_sec_end, {1'b0, s_dest}, s_dest_end);
    end

    always_comb begin
        // word entry needs bit 1 clear, thumb entry is always aligned
        main_mis = !r_main_entry[0] && r_main_entry[1];
        sec_mis  = !r_second_entry[0] && r_second_entry[1];
        if (r_pre != ERR_NONE) begin
            sec_code = r_pre;
        end else if (r_overlap) begin
            sec_code = ERR_OVERLAP;
        end else if (r_fb) begin
            sec_code = ERR_FRAMEBUF;
        end else if (!r_dig) begin
            sec_code = ERR_HASH;
        end else begin
            sec_code = ERR_NONE;
        end
        if ((r_main_entry == '0) || main_mis || !r_main_found) begin
            fin_code = ERR_MAIN_ENTRY;
        end else if ((r_second_entry != '0)
                     && (sec_mis || (r_sec_addr < SECOND_MIN) || !r_sec_found)) begin
            fin_code = ERR_SECOND_ENTRY;
        end else begin
            fin_code = ERR_NONE;
        end
        res_code = (r_mode == MODE_FINISH) ? fin_code : sec_code;
        store_en = i_cmd.resolve && (r_mode == MODE_SECTION) && (sec_code == ERR_NONE)
                   && (r_count < CNT_W'(MAX_SECTIONS));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= t_mode'(i_item.mode);
            r_off  <= i_item.sec_offset;
            r_dest <= i_item.sec_dest;
            r_len  <= i_item.sec_length;
            r_kind <= i_item.copy_kind;
            r_dig  <= i_item.digest_ok;
        end
        if (i_cmd.calc) begin
            r_off_end    <= {1'b0, r_off} + {1'b0, r_len};
            r_dest_end   <= {1'b0, r_dest} + {1'b0, r_len};
            r_main_addr  <= {r_main_entry[31:1], 1'b0};
            r_main_end   <= {1'b0, r_main_entry[31:1], 1'b0}
                            + (r_main_entry[0] ? ENTRY_W_THUMB : ENTRY_W_WORD);
            r_sec_addr   <= {r_second_entry[31:1], 1'b0};
            r_sec_end    <= {1'b0, r_second_entry[31:1], 1'b0}
                            + (r_second_entry[0] ? ENTRY_W_THUMB : ENTRY_W_WORD);
            r_idx        <= '0;
            r_overlap    <= 1'b0;
            r_main_found <= 1'b0;
            r_sec_found  <= 1'b0;
        end
        if (i_cmd.check) begin
            r_pre <= pre_code;
            r_fb  <= fb_hit;
        end
        if (i_cmd.scan) begin
            r_idx        <= r_idx + IDX_W'(1);
            r_overlap    <= r_overlap | scan_hit;
            r_main_found <= r_main_found | main_in;
            r_sec_found  <= r_sec_found | sec_in;
        end
        if (store_en) begin
            r_st_dest[r_count[IDX_W-1:0]] <= r_dest;
            r_st_len[r_count[IDX_W-1:0]]  <= r_len;
            r_st_off[r_count[IDX_W-1:0]]  <= r_off;
        end
        if (i_cmd.emit) begin
            r_out.accepted   <= (r_err == ERR_NONE);
            r_out.error_code <= r_err;
            r_out.held_count <= HELD_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_headers   <= '0;
            r_err       <= ERR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_img) begin
                r_count   <= '0;
                r_headers <= '0;
                r_err     <= ERR_NONE;
            end
            if (i_cmd.count_header) begin
                r_headers <= r_headers + CNT_W'(1);
            end
            if (i_cmd.set_too_many) begin
                r_err <= ERR_TOO_MANY;
            end
            if (i_cmd.resolve) begin
                r_err <= res_code;
            end
            if (store_en) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.mode         = r_mode;
        o_status.err_present  = (r_err != ERR_NONE);
        o_status.headers_full = (r_headers >= CNT_W'(MAX_SECTIONS));
        o_status.len_zero     = (r_len == '0);
        o_status.count_zero   = (r_count == '0);
        o_status.scan_last    = ((CW1'(r_idx) + CW1'(1)) == CW1'(r_count));
        o_status.out_free     = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

/* rtl/core/boot_image_section_validator.sv */
// channel   dir  handshake     payload
// i_sec     in   valid/ready   mode, sec_offset, sec_dest, sec_length, copy_kind, digest_ok
// o_res     out  valid/ready   accepted, error_code, held_count
// i_cfg     in   valid/ready   index, value (ready always high)
//
// a checked section item passes prep, check, a scan of the stored sections (skipped while
// none are held), resolve and emit, which registers the result; the scan walks the section
// store one entry a cycle. a finish item skips check; begin, unused-mode and early-out items
// go from prep straight to emit. input ready is high again once the result is registered.
// reset is synchronous and clears control state, counts, error and configuration; the
// store is not cleared, only entries below the held count are read.
// a waiting result sits in the output register while the next item is taken and worked;
// the following result then holds input ready low until that register frees.
module boot_image_section_validator #(
    parameter int MAX_SECTIONS = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bisv_in_if.sink   i_sec,
    bisv_out_if.source o_res,
    bisv_cfg_if.sink  i_cfg
);
    import bisv_pkg::*;

    t_cmd    cmd;
    t_status status;

    bisv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sec.valid),
        .o_in_ready (i_sec.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bisv_dp #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_item      (i_sec.data),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_value (i_cfg.value),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_out_item  (o_res.data)
    );

    assign i_cfg.ready = 1'b1;

endmodule

/* rtl/core/bisv_checker.sv */
`include "boot_image_section_validator_assert.svh"

module bisv_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input bisv_pkg::t_out_item i_out_item
);
    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_pending;
    logic [1:0] n_pending;

    assign in_acc    = i_in_valid && i_in_ready;
    assign out_acc   = i_out_valid && i_out_ready;
    assign n_pending = 2'(r_pending + {1'b0, in_acc} - {1'b0, out_acc});

    // items taken but whose result is not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    `BISV_ASSERT_IMP(a_no_orphan_result, i_clk, i_rst_n, i_out_valid, r_pending != 2'd0)
    `BISV_ASSERT_IMP(a_pending_bound, i_clk, i_rst_n, 1'b1, r_pending <= 2'd2)
    `BISV_ASSERT_NXT(a_one_in_work, i_clk, i_rst_n, in_acc, !i_in_ready)
    `BISV_ASSERT_NXT(a_result_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_item))

endmodule

bind boot_image_section_validator bisv_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sec.valid),
    .i_in_ready  (i_sec.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_item  (o_res.data)
);
